>>> hw/rtl/pcs_pkg.sv
// pcs_pkg: shared sizes, action codes, types and the degree encoder
// for the polynomial coefficient store; depends on nothing
package pcs_pkg;

    localparam int MAX_TERMS   = 16;
    localparam int COEFF_WIDTH = 32;
    localparam int IDX_W       = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

    // action codes
    localparam logic [2:0] ACT_SET  = 3'd0;
    localparam logic [2:0] ACT_ADD  = 3'd1;
    localparam logic [2:0] ACT_SUB  = 3'd2;
    localparam logic [2:0] ACT_READ = 3'd3;
    localparam logic [2:0] ACT_EVAL = 3'd4;

    typedef logic [COEFF_WIDTH-1:0] coeff_t;
    typedef logic [IDX_W-1:0]       idx_t;

    // per-cell control from the sequencer
    typedef struct packed {
        logic shift_en;
        logic wr_en;
    } cell_ctrl_t;

    // highest set flag, 0 when none is set
    function automatic idx_t degree_of(input logic [MAX_TERMS-1:0] mask);
        idx_t d;
        d = '0;
        for (int i = 0; i < MAX_TERMS; i++)
        begin
            if (mask[i])
            begin
                d = idx_t'(i);
            end
        end
        return d;
    endfunction

endpackage

>>> hw/rtl/polynomial_coeff_store_horner_eval.sv
// polynomial_coeff_store_horner_eval: top level, sequencer, ring of
// coefficient cells and the Horner unit; depends on pcs_pkg, pcs_cell, pcs_horner
//
// Holds one polynomial of up to MAX_TERMS coefficients in a ring of cells.
// A word is taken when start is high and busy is low; busy then stays high
// until the result has been shown. Each word yields one result on
// result_value and poly_degree, valid only in the single cycle where done is
// high; the receiver cannot stall, so it must capture it then. Set, add,
// subtract, read and unused actions go from accept through ST_OP to done. An
// evaluation goes through ST_OP and then ST_EVAL, in which the ring rotates
// once past the single multiply-add unit, one coefficient per cycle from the
// highest term down, and comes back to its starting place. No clearing pass
// is needed after reset.
module polynomial_coeff_store_horner_eval
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         action,
    input  logic [3:0]         term_index,
    input  logic signed [31:0] coeff_value,
    input  logic signed [31:0] eval_point,
    output logic               done,
    output logic signed [31:0] result_value,
    output logic [3:0]         poly_degree
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_OP   = 2'd1;
    localparam logic [1:0] ST_EVAL = 2'd2;
    localparam logic [1:0] ST_RESP = 2'd3;

    logic [1:0]      state_reg;
    logic [1:0]      state_next;
    logic [2:0]      action_reg;
    logic [3:0]      index_reg;
    pcs_pkg::coeff_t value_reg;
    pcs_pkg::coeff_t point_reg;
    pcs_pkg::coeff_t res_reg;
    pcs_pkg::coeff_t res_next;
    pcs_pkg::idx_t   step_cnt_reg;
    pcs_pkg::idx_t   step_cnt_next;

    logic            accept;
    logic            in_range;
    logic            step_last;
    pcs_pkg::idx_t   sel;
    pcs_pkg::coeff_t cur_coeff;
    pcs_pkg::coeff_t new_coeff;
    logic            wr_req;
    logic            shift_en;
    logic            mac_load;
    logic            mac_step;
    pcs_pkg::coeff_t acc_next;

    pcs_pkg::coeff_t            cell_coeff [pcs_pkg::MAX_TERMS];
    logic [pcs_pkg::MAX_TERMS-1:0] nz_mask;
    logic [pcs_pkg::MAX_TERMS-1:0] coeff_nz;

    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE);
    assign done      = (state_reg == ST_RESP);
    assign in_range  = (int'(index_reg) < pcs_pkg::MAX_TERMS);
    assign sel       = pcs_pkg::idx_t'(index_reg);
    assign cur_coeff = cell_coeff[sel];
    assign step_last = (step_cnt_reg == pcs_pkg::idx_t'(pcs_pkg::MAX_TERMS - 1));

    // capture the input word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= action;
            index_reg  <= term_index;
            value_reg  <= pcs_pkg::COEFF_WIDTH'(coeff_value);
            point_reg  <= pcs_pkg::COEFF_WIDTH'(eval_point);
        end
    end

    // updated coefficient for the write actions
    always_comb
    begin
        case (action_reg)
            pcs_pkg::ACT_ADD: new_coeff = cur_coeff + value_reg;
            pcs_pkg::ACT_SUB: new_coeff = cur_coeff - value_reg;
            default:          new_coeff = value_reg;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        res_next      = res_reg;
        step_cnt_next = step_cnt_reg;
        wr_req        = 1'b0;
        shift_en      = 1'b0;
        mac_load      = 1'b0;
        mac_step      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_OP;
                end
            end
            ST_OP:
            begin
                state_next = ST_RESP;
                res_next   = '0;
                case (action_reg) inside
                    pcs_pkg::ACT_SET, pcs_pkg::ACT_ADD, pcs_pkg::ACT_SUB:
                    begin
                        if (in_range)
                        begin
                            wr_req   = 1'b1;
                            res_next = new_coeff;
                        end
                    end
                    pcs_pkg::ACT_READ:
                    begin
                        if (in_range)
                        begin
                            res_next = cur_coeff;
                        end
                    end
                    pcs_pkg::ACT_EVAL:
                    begin
                        mac_load      = 1'b1;
                        step_cnt_next = '0;
                        state_next    = ST_EVAL;
                    end
                    default:
                    begin
                        res_next = '0;
                    end
                endcase
            end
            ST_EVAL:
            begin
                shift_en      = 1'b1;
                mac_step      = 1'b1;
                step_cnt_next = step_cnt_reg + 1'b1;
                if (step_last)
                begin
                    res_next   = acc_next;
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            step_cnt_reg <= step_cnt_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    // ring of cells, each taking from its lower neighbor
    for (genvar g = 0; g < pcs_pkg::MAX_TERMS; g++)
    begin : g_cell
        localparam int PREV = (g + pcs_pkg::MAX_TERMS - 1) % pcs_pkg::MAX_TERMS;
        pcs_pkg::cell_ctrl_t ctrl;

        assign ctrl.shift_en = shift_en;
        assign ctrl.wr_en    = wr_req && (sel == pcs_pkg::idx_t'(g));

        pcs_cell u_cell
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .shift_in    (cell_coeff[PREV]),
            .shift_nz_in (nz_mask[PREV]),
            .wr_data     (new_coeff),
            .coeff       (cell_coeff[g]),
            .nonzero     (nz_mask[g])
        );

        assign coeff_nz[g] = (cell_coeff[g] != '0);
    end

    // multiply-add fed from the top cell of the ring
    pcs_horner u_horner
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (mac_load),
        .step     (mac_step),
        .x_in     (point_reg),
        .coeff_in (cell_coeff[pcs_pkg::MAX_TERMS-1]),
        .acc_next (acc_next)
    );

    // result ports
    assign result_value = 32'($signed(res_reg));
    assign poly_degree  = 4'(pcs_pkg::degree_of(nz_mask));

    // checks
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("busy not raised after accept");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("done held longer than one cycle");

    a_mask_match: assert property (@(posedge clk) disable iff (!rst_n)
        nz_mask == coeff_nz)
        else $error("nonzero flags disagree with stored coefficients");

    a_eval_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVAL) && step_last |=> done)
        else $error("evaluation did not end in a result");

endmodule

>>> hw/rtl/pcs_cell.sv
// pcs_cell: one coefficient and its nonzero flag, a stage of the ring
// depends on pcs_pkg
module pcs_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  pcs_pkg::cell_ctrl_t ctrl,
    input  pcs_pkg::coeff_t     shift_in,
    input  logic                shift_nz_in,
    input  pcs_pkg::coeff_t     wr_data,
    output pcs_pkg::coeff_t     coeff,
    output logic                nonzero
);

    pcs_pkg::coeff_t coeff_reg;
    pcs_pkg::coeff_t coeff_next;
    logic            nz_reg;
    logic            nz_next;

    // rotate with the neighbor or take a direct write
    always_comb
    begin
        coeff_next = coeff_reg;
        nz_next    = nz_reg;
        if (ctrl.shift_en)
        begin
            coeff_next = shift_in;
            nz_next    = shift_nz_in;
        end
        else if (ctrl.wr_en)
        begin
            coeff_next = wr_data;
            nz_next    = (wr_data != '0);
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_reg <= '0;
            nz_reg    <= 1'b0;
        end
        else
        begin
            coeff_reg <= coeff_next;
            nz_reg    <= nz_next;
        end
    end

    assign coeff   = coeff_reg;
    assign nonzero = nz_reg;

endmodule

>>> hw/rtl/pcs_horner.sv
// pcs_horner: multiply-add unit that folds one coefficient per step
// depends on pcs_pkg
module pcs_horner
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  logic            step,
    input  pcs_pkg::coeff_t x_in,
    input  pcs_pkg::coeff_t coeff_in,
    output pcs_pkg::coeff_t acc_next
);

    pcs_pkg::coeff_t acc_reg;
    pcs_pkg::coeff_t x_reg;
    pcs_pkg::coeff_t product;

    // acc * x + c, wrapping at the coefficient width
    assign product  = acc_reg * x_reg;
    assign acc_next = product + coeff_in;

    // accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (load)
        begin
            acc_reg <= '0;
        end
        else if (step)
        begin
            acc_reg <= acc_next;
        end
    end

    // evaluation point
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg <= x_in;
        end
    end

endmodule
